// ===== hdl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// Shared constants, types and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int DATA_WIDTH    = 32;
   localparam int FRAC_BITS     = 16;
   localparam int CORDIC_STAGES = 16;
   localparam int QUO_BITS      = 32;
   localparam int NUM_CELLS     = 32;
   localparam int IDX_W         = 5;
   localparam int TOL_W         = 31;
   localparam int ANG_W         = 35;
   localparam int ANG_SHIFT     = 30 - FRAC_BITS;

   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 35'sd1686629713;
   localparam logic [DATA_WIDTH-1:0]   SAT_HI      = 32'h7FFF_FFFF;
   localparam logic [DATA_WIDTH-1:0]   SAT_LO      = 32'h8000_0000;

   typedef logic [3:0] action_type;

   localparam action_type ACT_ADD      = 4'd0;
   localparam action_type ACT_SUB      = 4'd1;
   localparam action_type ACT_MUL      = 4'd2;
   localparam action_type ACT_DIV      = 4'd3;
   localparam action_type ACT_DIV_REAL = 4'd4;
   localparam action_type ACT_EQUAL    = 4'd5;
   localparam action_type ACT_MAG      = 4'd6;
   localparam action_type ACT_ANGLE    = 4'd7;
   localparam action_type ACT_CONJ     = 4'd8;

   // one item as it travels down the cell row
   typedef struct packed {
      action_type        action;
      logic [31:0]       fast_re;
      logic [31:0]       fast_im;
      logic              fast_eq;
      logic              fast_ov;
      logic              div_zero;
      logic              ar_neg;
      logic              ai_neg;
      logic              angle_zero;
      logic              neg_re;
      logic              neg_im;
      logic              big_re;
      logic              big_im;
      logic [63:0]       dvs;
      logic [63:0]       rem_re;
      logic [63:0]       rem_im;
      logic [31:0]       num_re;
      logic [31:0]       num_im;
      logic [31:0]       quo_re;
      logic [31:0]       quo_im;
      logic [63:0]       sq_s;
      logic [63:0]       sq_res;
      logic [ANG_W-1:0]  cx;
      logic [ANG_W-1:0]  cy;
      logic [ANG_W-1:0]  cz;
   } cell_data_type;

   // atan(2^-i) in Q2.30
   function automatic logic [29:0] atan_q30(input logic [IDX_W-1:0] i);
      logic [29:0] v;
      case (i)
         5'd0:  v = 30'd843314857;
         5'd1:  v = 30'd497837829;
         5'd2:  v = 30'd263043837;
         5'd3:  v = 30'd133525159;
         5'd4:  v = 30'd67021687;
         5'd5:  v = 30'd33543516;
         5'd6:  v = 30'd16775851;
         5'd7:  v = 30'd8388438;
         5'd8:  v = 30'd4194283;
         5'd9:  v = 30'd2097150;
         5'd10: v = 30'd1048576;
         5'd11: v = 30'd524288;
         5'd12: v = 30'd262144;
         5'd13: v = 30'd131072;
         5'd14: v = 30'd65536;
         5'd15: v = 30'd32768;
         5'd16: v = 30'd16384;
         5'd17: v = 30'd8192;
         5'd18: v = 30'd4096;
         5'd19: v = 30'd2048;
         5'd20: v = 30'd1024;
         5'd21: v = 30'd512;
         5'd22: v = 30'd256;
         5'd23: v = 30'd128;
         5'd24: v = 30'd64;
         5'd25: v = 30'd32;
         5'd26: v = 30'd16;
         5'd27: v = 30'd8;
         5'd28: v = 30'd4;
         5'd29: v = 30'd2;
         5'd30: v = 30'd1;
         default: v = 30'd0;
      endcase
      return v;
   endfunction

   // saturate to signed 32 bits; msb of result is the overflow flag
   function automatic logic [32:0] sat32(input logic signed [65:0] v);
      logic [32:0] r;
      if (v > 66'sh7FFF_FFFF) begin
         r = {1'b1, SAT_HI};
      end else if (v < -66'sh8000_0000) begin
         r = {1'b1, SAT_LO};
      end else begin
         r = {1'b0, v[31:0]};
      end
      return r;
   endfunction

endpackage

// ===== hdl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// Input register, products, sums, short actions and setup of the cell row.
// ----------------------------------------------------------------------------
module cau_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  cau_pkg::action_type   in_action,
   input  logic signed [31:0]    in_a_re,
   input  logic signed [31:0]    in_a_im,
   input  logic signed [31:0]    in_b_re,
   input  logic signed [31:0]    in_b_im,
   input  logic [30:0]           tol,
   output logic                  out_valid,
   output cau_pkg::cell_data_type out_data
);
   import cau_pkg::*;

   logic v0_ff, v1_ff, v2_ff, v3_ff;
   action_type act0_ff, act1_ff, act2_ff;
   logic signed [31:0] ar0_ff, ai0_ff, br0_ff, bi0_ff;
   logic signed [31:0] ar1_ff, ai1_ff, br1_ff, bi1_ff;
   logic signed [31:0] ar2_ff, ai2_ff, br2_ff, bi2_ff;

   logic signed [63:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [63:0] p_bb_r_ff, p_bb_i_ff, p_aa_r_ff, p_aa_i_ff;

   logic signed [64:0] mre2_ff, mim2_ff, dnre2_ff, dnim2_ff;
   logic [63:0]        dd2_ff, msq2_ff;

   cell_data_type d3_ff, d3_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         act0_ff <= in_action;
         ar0_ff  <= in_a_re;
         ai0_ff  <= in_a_im;
         br0_ff  <= in_b_re;
         bi0_ff  <= in_b_im;
         // products
         act1_ff   <= act0_ff;
         ar1_ff    <= ar0_ff;
         ai1_ff    <= ai0_ff;
         br1_ff    <= br0_ff;
         bi1_ff    <= bi0_ff;
         p_rr_ff   <= ar0_ff * br0_ff;
         p_ii_ff   <= ai0_ff * bi0_ff;
         p_ri_ff   <= ar0_ff * bi0_ff;
         p_ir_ff   <= ai0_ff * br0_ff;
         p_bb_r_ff <= br0_ff * br0_ff;
         p_bb_i_ff <= bi0_ff * bi0_ff;
         p_aa_r_ff <= ar0_ff * ar0_ff;
         p_aa_i_ff <= ai0_ff * ai0_ff;
         // sums wrap at 64 bits, then sign-extend
         act2_ff  <= act1_ff;
         ar2_ff   <= ar1_ff;
         ai2_ff   <= ai1_ff;
         br2_ff   <= br1_ff;
         bi2_ff   <= bi1_ff;
         mre2_ff  <= 65'($signed(p_rr_ff - p_ii_ff));
         mim2_ff  <= 65'($signed(p_ri_ff + p_ir_ff));
         dnre2_ff <= 65'($signed(p_rr_ff + p_ii_ff));
         dnim2_ff <= 65'($signed(p_ir_ff - p_ri_ff));
         dd2_ff   <= $unsigned(p_bb_r_ff) + $unsigned(p_bb_i_ff);
         msq2_ff  <= $unsigned(p_aa_r_ff) + $unsigned(p_aa_i_ff);
         d3_ff    <= d3_in;
      end
   end

   logic [32:0]        sr, si;
   logic signed [32:0] dre, dim;
   logic [32:0]        adre, adim;
   logic signed [64:0] nre, nim;
   logic [63:0]        anre, anim, dv;
   logic signed [ANG_W-1:0] x0, y0;

   always_comb begin
      d3_in = '0;
      d3_in.action = act2_ff;
      d3_in.ar_neg = ar2_ff[31];
      d3_in.ai_neg = ai2_ff[31];
      sr   = '0;
      si   = '0;
      dre  = 33'(ar2_ff) - 33'(br2_ff);
      dim  = 33'(ai2_ff) - 33'(bi2_ff);
      adre = dre[32] ? 33'(-dre) : 33'(dre);
      adim = dim[32] ? 33'(-dim) : 33'(dim);

      case (act2_ff)
         ACT_ADD: begin
            sr = sat32(66'(ar2_ff) + 66'(br2_ff));
            si = sat32(66'(ai2_ff) + 66'(bi2_ff));
         end
         ACT_SUB: begin
            sr = sat32(66'(ar2_ff) - 66'(br2_ff));
            si = sat32(66'(ai2_ff) - 66'(bi2_ff));
         end
         ACT_MUL: begin
            sr = sat32(66'(mre2_ff >>> FRAC_BITS));
            si = sat32(66'(mim2_ff >>> FRAC_BITS));
         end
         ACT_EQUAL: begin
            d3_in.fast_eq = (adre < {2'b00, tol}) && (adim < {2'b00, tol});
         end
         ACT_CONJ: begin
            sr = {1'b0, ar2_ff};
            si = sat32(-66'(ai2_ff));
         end
         default: ;
      endcase
      d3_in.fast_re = sr[31:0];
      d3_in.fast_im = si[31:0];
      d3_in.fast_ov = sr[32] | si[32];

      // divider setup: complex divide or divide by a real
      if (act2_ff == ACT_DIV) begin
         nre = dnre2_ff;
         nim = dnim2_ff;
         dv  = dd2_ff;
         d3_in.neg_re   = nre[64];
         d3_in.neg_im   = nim[64];
         d3_in.div_zero = (dd2_ff == 64'd0);
      end else begin
         nre = 65'(ar2_ff);
         nim = 65'(ai2_ff);
         dv  = br2_ff[31] ? 64'(-65'(br2_ff)) : 64'(br2_ff);
         d3_in.neg_re   = ar2_ff[31] ^ br2_ff[31];
         d3_in.neg_im   = ai2_ff[31] ^ br2_ff[31];
         d3_in.div_zero = (act2_ff == ACT_DIV_REAL) && (br2_ff == 32'sd0);
      end
      anre = nre[64] ? 64'(-nre) : 64'(nre);
      anim = nim[64] ? 64'(-nim) : 64'(nim);
      d3_in.dvs    = dv;
      // quotient needs more than QUO_BITS bits
      d3_in.big_re = {16'd0, anre} >= {dv, 16'd0};
      d3_in.big_im = {16'd0, anim} >= {dv, 16'd0};
      d3_in.rem_re = anre >> FRAC_BITS;
      d3_in.rem_im = anim >> FRAC_BITS;
      d3_in.num_re = {anre[15:0], 16'd0};
      d3_in.num_im = {anim[15:0], 16'd0};

      d3_in.sq_s   = msq2_ff;

      // rotate into the right half plane
      x0 = ANG_W'(ar2_ff);
      y0 = ANG_W'(ai2_ff);
      d3_in.angle_zero = (ar2_ff == 32'sd0) && (ai2_ff == 32'sd0);
      if (ar2_ff[31]) begin
         if (!ai2_ff[31]) begin
            d3_in.cx = y0;
            d3_in.cy = -x0;
            d3_in.cz = HALF_PI_Q30;
         end else begin
            d3_in.cx = -y0;
            d3_in.cy = x0;
            d3_in.cz = -HALF_PI_Q30;
         end
      end else begin
         d3_in.cx = x0;
         d3_in.cy = y0;
      end
   end

   assign out_valid = v3_ff;
   assign out_data  = d3_ff;

endmodule

// ===== hdl/cau_cell.sv =====
// ----------------------------------------------------------------------------
// cau_cell
// One step of both dividers, the square root and the CORDIC rotation.
// ----------------------------------------------------------------------------
module cau_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [cau_pkg::IDX_W-1:0]   idx,
   input  logic                        in_valid,
   input  cau_pkg::cell_data_type      in_data,
   output logic                        out_valid,
   output cau_pkg::cell_data_type      out_data
);
   import cau_pkg::*;

   logic          valid_ff;
   cell_data_type data_ff, data_in;

   logic [64:0]   t_re, t_im;
   logic [6:0]    sh;
   logic [63:0]   sbit, trial;
   logic signed [ANG_W-1:0] x, y, z, xs, ys;

   always_comb begin
      data_in = in_data;

      // restoring divide: bring in one dividend bit
      t_re = {in_data.rem_re, in_data.num_re[31]};
      t_im = {in_data.rem_im, in_data.num_im[31]};
      data_in.num_re = {in_data.num_re[30:0], 1'b0};
      data_in.num_im = {in_data.num_im[30:0], 1'b0};
      if (t_re >= {1'b0, in_data.dvs}) begin
         data_in.rem_re = 64'(t_re - {1'b0, in_data.dvs});
         data_in.quo_re = {in_data.quo_re[30:0], 1'b1};
      end else begin
         data_in.rem_re = t_re[63:0];
         data_in.quo_re = {in_data.quo_re[30:0], 1'b0};
      end
      if (t_im >= {1'b0, in_data.dvs}) begin
         data_in.rem_im = 64'(t_im - {1'b0, in_data.dvs});
         data_in.quo_im = {in_data.quo_im[30:0], 1'b1};
      end else begin
         data_in.rem_im = t_im[63:0];
         data_in.quo_im = {in_data.quo_im[30:0], 1'b0};
      end

      // square root, one result bit per cell from two bits of the radicand
      sh    = 7'd62 - 7'({idx, 1'b0});
      sbit  = 64'd1 << sh;
      trial = in_data.sq_res + sbit;
      if (in_data.sq_s >= trial) begin
         data_in.sq_s   = in_data.sq_s - trial;
         data_in.sq_res = (in_data.sq_res >> 1) + sbit;
      end else begin
         data_in.sq_res = in_data.sq_res >> 1;
      end

      // vectoring CORDIC
      x  = $signed(in_data.cx);
      y  = $signed(in_data.cy);
      z  = $signed(in_data.cz);
      xs = x >>> idx;
      ys = y >>> idx;
      if (int'(idx) < CORDIC_STAGES) begin
         if (!y[ANG_W-1]) begin
            data_in.cx = x + ys;
            data_in.cy = y - xs;
            data_in.cz = z + ANG_W'(atan_q30(idx));
         end else begin
            data_in.cx = x - ys;
            data_in.cy = y + xs;
            data_in.cz = z - ANG_W'(atan_q30(idx));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== hdl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// Sign, saturation and action select after the cell row; output register.
// ----------------------------------------------------------------------------
module cau_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  cau_pkg::cell_data_type in_data,
   output logic                   out_valid,
   output logic [31:0]            out_re,
   output logic [31:0]            out_im,
   output logic                   out_eq,
   output logic                   out_dz,
   output logic                   out_ov
);
   import cau_pkg::*;

   logic        valid_ff;
   logic [31:0] re_ff, im_ff, re_in, im_in;
   logic        eq_ff, dz_ff, ov_ff, eq_in, dz_in, ov_in;

   logic [32:0] qre, qim;
   logic signed [ANG_W-1:0] zr;

   function automatic logic [32:0] div_sat(input logic [31:0] q, input logic big,
                                           input logic neg);
      logic [32:0] r;
      if (big) begin
         r = {1'b1, neg ? SAT_LO : SAT_HI};
      end else if (!neg) begin
         r = q[31] ? {1'b1, SAT_HI} : {1'b0, q};
      end else begin
         r = (q > SAT_LO) ? {1'b1, SAT_LO} : {1'b0, 32'(-q)};
      end
      return r;
   endfunction

   always_comb begin
      qre   = div_sat(in_data.quo_re, in_data.big_re, in_data.neg_re);
      qim   = div_sat(in_data.quo_im, in_data.big_im, in_data.neg_im);
      zr    = ($signed(in_data.cz) + $signed(ANG_W'(1 << (ANG_SHIFT - 1)))) >>> ANG_SHIFT;
      re_in = '0;
      im_in = '0;
      eq_in = 1'b0;
      dz_in = 1'b0;
      ov_in = 1'b0;
      case (in_data.action) inside
         ACT_ADD, ACT_SUB, ACT_MUL, ACT_CONJ: begin
            re_in = in_data.fast_re;
            im_in = in_data.fast_im;
            ov_in = in_data.fast_ov;
         end
         ACT_EQUAL: begin
            eq_in = in_data.fast_eq;
         end
         ACT_DIV, ACT_DIV_REAL: begin
            if (in_data.div_zero) begin
               re_in = in_data.ar_neg ? SAT_LO : SAT_HI;
               im_in = in_data.ai_neg ? SAT_LO : SAT_HI;
               dz_in = 1'b1;
            end else begin
               re_in = qre[31:0];
               im_in = qim[31:0];
               ov_in = qre[32] | qim[32];
            end
         end
         ACT_MAG: begin
            if (in_data.sq_res[63:31] != 33'd0) begin
               re_in = SAT_HI;
               ov_in = 1'b1;
            end else begin
               re_in = in_data.sq_res[31:0];
            end
         end
         ACT_ANGLE: begin
            re_in = in_data.angle_zero ? 32'd0 : zr[31:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         re_ff <= re_in;
         im_ff <= im_in;
         eq_ff <= eq_in;
         dz_ff <= dz_in;
         ov_ff <= ov_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_re    = re_ff;
   assign out_im    = im_ff;
   assign out_eq    = eq_ff;
   assign out_dz    = dz_ff;
   assign out_ov    = ov_ff;

endmodule

// ===== hdl/complex_arith_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arith_unit
// Complex ALU on signed Q16.16: add, sub, mul, divide, divide by real,
// compare, magnitude, angle, conjugate.
//
//   port group | dir | beat contents
//   req_       | in  | tuser: action; tdata: a_re, a_im, b_re, b_im
//   rsp_       | out | tdata: res_re, res_im, is_equal, div_zero, overflowed
//   csr_       | in  | equal_tolerance write
//
// One beat per cycle sustained while not stalled; stages in order: input, multiply,
// sum, setup, 32 cells (divider bit, root step, CORDIC step in the first 16), output.
// The whole pipe advances together; rsp_tready low with a beat waiting holds
// every stage and drops req_tready. Reset empties the pipe and sets the
// tolerance to 7.
// ----------------------------------------------------------------------------
module complex_arith_unit (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [127:0]  req_tdata,   // a_re, a_im, b_re, b_im
   input  logic [3:0]    req_tuser,   // action
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [71:0]   rsp_tdata,   // res_re, res_im, is_equal, div_zero, overflowed
   input  logic          csr_wr_en,
   input  logic [30:0]   csr_wr_data
);
   import cau_pkg::*;

   logic [TOL_W-1:0] tol_ff;
   logic             en;

   logic          chain_valid [NUM_CELLS+1];
   cell_data_type chain_data  [NUM_CELLS+1];

   logic [31:0] res_re, res_im;
   logic        is_equal, div_zero, overflowed;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 31'd7;
      end else if (csr_wr_en) begin
         tol_ff <= csr_wr_data;
      end
   end

   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_action (req_tuser),
      .in_a_re   (req_tdata[31:0]),
      .in_a_im   (req_tdata[63:32]),
      .in_b_re   (req_tdata[95:64]),
      .in_b_im   (req_tdata[127:96]),
      .tol       (tol_ff),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
      cau_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .idx       (IDX_W'(k)),
         .in_valid  (chain_valid[k]),
         .in_data   (chain_data[k]),
         .out_valid (chain_valid[k+1]),
         .out_data  (chain_data[k+1])
      );
   end

   cau_back u_back (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (chain_valid[NUM_CELLS]),
      .in_data   (chain_data[NUM_CELLS]),
      .out_valid (rsp_tvalid),
      .out_re    (res_re),
      .out_im    (res_im),
      .out_eq    (is_equal),
      .out_dz    (div_zero),
      .out_ov    (overflowed)
   );

   assign rsp_tdata = {5'd0, overflowed, div_zero, is_equal, res_im, res_re};

endmodule
